FILE: sv/murmur2_hash_stream_defines.svh
// Assertion macros shared by the murmur2_hash_stream RTL.
// Depends on a clk and rst signal in the scope of each use.
`ifndef MURMUR2_HASH_STREAM_DEFINES_SVH
`define MURMUR2_HASH_STREAM_DEFINES_SVH

// Check a property on every rising clk edge outside reset.
`define MH2_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define MH2_ASSERT_NEXT(label, ante, cons, msg) \
  `MH2_ASSERT(label, (ante) |=> (cons), msg)

`endif

FILE: sv/mh2_pkg.sv
// Package for the MurmurHash2 stream block: constants, word kinds, queue entry.
// No dependencies; every other file but the assertion macros header imports it.
`timescale 1ns / 1ps

package mh2_pkg;

  localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
  localparam int          MIX_SHIFT   = 24;
  localparam int          FIN_SHIFT_A = 13;
  localparam int          FIN_SHIFT_B = 15;
  localparam logic [31:0] SEED_RESET  = 32'd5381;

  localparam int WORD_W  = 32;
  localparam int COUNT_W = 3;
  localparam int KLEN_W  = 31;

  localparam int QUEUE_DEPTH_DEF = 4;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_TAIL,
    KIND_BLOCK
  } word_kind_t;

  // One classified word between front and back: for a block the fully mixed k,
  // for a tail the masked bytes.
  typedef struct packed {
    logic [WORD_W-1:0] mix_val;
    word_kind_t        kind;
    logic              first;
    logic              last;
    logic [KLEN_W-1:0] key_length;
  } mix_entry_t;

endpackage

FILE: sv/mh2_key_if.sv
// Key word channel: valid/ready handshake with the key word fields.
// Depends on mh2_pkg.
`timescale 1ns / 1ps

interface mh2_key_if import mh2_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  data_word;
  logic [COUNT_W-1:0] byte_count;
  logic               first_word;
  logic               last_word;
  logic [KLEN_W-1:0]  key_length;

  modport source (output valid, data_word, byte_count, first_word, last_word, key_length,
                  input ready);
  modport sink   (input valid, data_word, byte_count, first_word, last_word, key_length,
                  output ready);
endinterface

FILE: sv/mh2_hash_if.sv
// Hash result channel: valid/ready handshake with the finished hash.
// Depends on mh2_pkg.
`timescale 1ns / 1ps

interface mh2_hash_if import mh2_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

FILE: sv/mh2_front.sv
// Front end: accepts key word beats, classifies them and mixes block words.
// Depends on mh2_pkg and mh2_key_if; feeds mh2_queue.
`timescale 1ns / 1ps

module mh2_front import mh2_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mh2_key_if.sink    key_in,
  output logic       push_valid,
  output mix_entry_t push_entry,
  input  logic       push_ready
);

  word_kind_t        in_kind;
  logic [WORD_W-1:0] in_mask;

  logic              s1_valid;
  logic [WORD_W-1:0] s1_prod;
  logic [WORD_W-1:0] s1_word;
  word_kind_t        s1_kind;
  logic              s1_first;
  logic              s1_last;
  logic [KLEN_W-1:0] s1_klen;
  logic [WORD_W-1:0] s1_fold;

  logic              s2_valid;
  mix_entry_t        s2_entry;

  logic              s1_adv;
  logic              s2_adv;

  always_comb begin
    unique case (key_in.byte_count)
      3'd0: begin
        in_kind = KIND_NONE;
        in_mask = 32'h0000_0000;
      end
      3'd1: begin
        in_kind = KIND_TAIL;
        in_mask = 32'h0000_00ff;
      end
      3'd2: begin
        in_kind = KIND_TAIL;
        in_mask = 32'h0000_ffff;
      end
      3'd3: begin
        in_kind = KIND_TAIL;
        in_mask = 32'h00ff_ffff;
      end
      default: begin
        in_kind = KIND_BLOCK;
        in_mask = 32'hffff_ffff;
      end
    endcase
  end

  assign s2_adv       = !s2_valid || push_ready;
  assign s1_adv       = !s1_valid || s2_adv;
  assign key_in.ready = s1_adv;
  assign s1_fold      = s1_prod ^ (s1_prod >> MIX_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid <= key_in.valid;
      end
      if (s2_adv) begin
        s2_valid <= s1_valid;
      end
    end
  end

  // First multiply of k, held with the masked bytes.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_prod  <= key_in.data_word * MIX_MUL;
      s1_word  <= key_in.data_word & in_mask;
      s1_kind  <= in_kind;
      s1_first <= key_in.first_word;
      s1_last  <= key_in.last_word;
      s1_klen  <= key_in.key_length;
    end
  end

  // Fold and second multiply; tails pass their masked bytes.
  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s2_entry.mix_val    <= (s1_kind == KIND_BLOCK) ? s1_fold * MIX_MUL : s1_word;
      s2_entry.kind       <= s1_kind;
      s2_entry.first      <= s1_first;
      s2_entry.last       <= s1_last;
      s2_entry.key_length <= s1_klen;
    end
  end

  assign push_valid = s2_valid;
  assign push_entry = s2_entry;

endmodule

FILE: sv/mh2_queue.sv
// Short FIFO of classified words between front and back.
// Depends on mh2_pkg.
`timescale 1ns / 1ps

module mh2_queue import mh2_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  input  mix_entry_t push_entry,
  output logic       push_ready,
  output logic       pop_valid,
  output mix_entry_t pop_entry,
  input  logic       pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mix_entry_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_entry  = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

FILE: sv/mh2_back.sv
// Back end: folds words into the running hash, finalizes and emits the result.
// Depends on mh2_pkg, mh2_hash_if and the assertion macros header.
`timescale 1ns / 1ps
`include "murmur2_hash_stream_defines.svh"

module mh2_back import mh2_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [WORD_W-1:0] hash_seed,
  input  logic              q_valid,
  input  mix_entry_t        q_entry,
  output logic              q_pop,
  mh2_hash_if.source        hash_out
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIN,
    ST_OUT
  } back_state_t;

  back_state_t       state;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] xv;
  logic              out_valid;
  logic [WORD_W-1:0] out_hash;

  logic [WORD_W-1:0] hval;
  logic [WORD_W-1:0] h0;
  logic [WORD_W-1:0] mul_in;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] fin_val;

  // Running hash is acc with the block xor still pending in xv.
  assign hval    = acc ^ xv;
  assign h0      = q_entry.first ? (hash_seed ^ {1'b0, q_entry.key_length}) : hval;
  assign q_pop   = (state == ST_IDLE) && q_valid;
  assign fin_val = acc ^ (acc >> FIN_SHIFT_B);

  always_comb begin
    if (state == ST_FIN) begin
      mul_in = hval ^ (hval >> FIN_SHIFT_A);
    end else if (q_entry.kind == KIND_TAIL) begin
      mul_in = h0 ^ q_entry.mix_val;
    end else begin
      mul_in = h0;
    end
  end

  assign prod = mul_in * MIX_MUL;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      acc       <= '0;
      xv        <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one replaces it this cycle.
      if (out_valid && hash_out.ready && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            unique case (q_entry.kind)
              KIND_BLOCK: begin
                acc <= prod;
                xv  <= q_entry.mix_val;
              end
              KIND_TAIL: begin
                acc <= prod;
                xv  <= '0;
              end
              default: begin
                acc <= h0;
                xv  <= '0;
              end
            endcase
            if (q_entry.last) begin
              state <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          acc   <= prod;
          xv    <= '0;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || hash_out.ready) begin
            out_hash  <= fin_val;
            out_valid <= 1'b1;
            acc       <= fin_val;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign hash_out.valid      = out_valid;
  assign hash_out.hash_value = out_hash;

  `MH2_ASSERT_NEXT(a_fin_then_out, state == ST_FIN, state == ST_OUT, "finalize did not advance")
  `MH2_ASSERT_NEXT(a_last_then_fin, q_pop && q_entry.last, state == ST_FIN, "last word missed")
  `MH2_ASSERT(a_result_from_out, $rose(out_valid) |-> $past(state == ST_OUT), "stray result")

endmodule

FILE: sv/murmur2_hash_stream.sv
// Top level of the streaming 32-bit MurmurHash2 block: seed register and the
// front, queue and back instances. Depends on mh2_pkg, both channel interfaces,
// mh2_front, mh2_queue and mh2_back.
`timescale 1ns / 1ps

// Hashes a key delivered as little-endian 32-bit word beats on key_in and returns
// one hash_value beat on hash_out per key, on the beat marked last_word. A word of
// four or more bytes is a full block, one to three bytes a tail, zero bytes adds
// nothing; first_word loads the hash with hash_seed XOR key_length. hash_seed is
// written through cfg_wr_en/cfg_wr_data and resets to 5381; the user must write it only
// while no key is in flight, as the block does not enforce this. Rate: the front mixes
// block words in a two-stage multiply pipeline and takes one beat per cycle while the
// queue has room; the back folds one word per cycle into the running hash through its
// single multiplier while in its idle state, and a last word then passes through fold,
// finalize multiply and result register, the last waiting for hash_out to take the
// previous result. The queue of QUEUE_DEPTH words lets the front keep accepting while
// the back finalizes or the result waits to be taken.
module murmur2_hash_stream import mh2_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [WORD_W-1:0] cfg_wr_data,
  mh2_key_if.sink           key_in,
  mh2_hash_if.source        hash_out
);

  logic [WORD_W-1:0] hash_seed;

  logic       push_valid;
  mix_entry_t push_entry;
  logic       push_ready;
  logic       q_valid;
  mix_entry_t q_entry;
  logic       q_pop;

  // Hold the seed; the back reads it when a first word leaves the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed <= SEED_RESET;
    end else if (cfg_wr_en) begin
      hash_seed <= cfg_wr_data;
    end
  end

  // Classify beats and premix block words.
  mh2_front u_front (
    .clk        (clk),
    .rst        (rst),
    .key_in     (key_in),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  // Decouple the premix pipeline from the running-hash loop.
  mh2_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_entry  (q_entry),
    .pop        (q_pop)
  );

  // Advance the running hash, finalize and drive the result register.
  mh2_back u_back (
    .clk       (clk),
    .rst       (rst),
    .hash_seed (hash_seed),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .hash_out  (hash_out)
  );

endmodule

FILE: tb/murmur2_hash_stream_test.sv
// Self-checking testbench for murmur2_hash_stream: streams key word beats, predicts
// every finished hash and checks the hash beats in order. Depends on mh2_pkg,
// mh2_key_if, mh2_hash_if and the murmur2_hash_stream RTL.
`timescale 1ns / 1ps

module murmur2_hash_stream_test import mh2_pkg::*; ();

  // Mixing constant of the 32-bit MurmurHash2 and the reset seed, kept here so the predictor
  // stands on its own.
  localparam logic [31:0] HASH_MUL   = 32'h5bd1e995;
  localparam logic [31:0] RESET_SEED = 32'd5381;

  // Cycles to let the block run dry after the last hash beat. A key word with
  // no last mark produces nothing, so an empty expectation queue does not mean
  // the block is idle.
  localparam int SETTLE_CYCLES = 24;
  // Cycles with no beat on either channel before the run is declared hung.
  localparam int IDLE_LIMIT    = 600;
  // Key beat budget per seed setting in the random part; the closing key comes on top.
  localparam int PHASE_BEATS   = 255;
  localparam int SEED_PHASES   = 6;
  localparam int DIRECTED_ROWS = 20;

  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic [COUNT_W-1:0] count;
    logic               first;
    logic               last;
    logic [KLEN_W-1:0]  klen;
  } key_beat_t;

  // One row of the directed table. Where the hash is obvious it is typed in
  // and checked as is; otherwise the predictor supplies it.
  typedef struct packed {
    key_beat_t   beat;
    logic        known;
    logic [31:0] known_hash;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [WORD_W-1:0] cfg_wr_data;

  mh2_key_if  key_ch ();
  mh2_hash_if hash_ch ();

  murmur2_hash_stream uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .key_in     (key_ch),
    .hash_out   (hash_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: the seed as last written and the hash carried between
  // words. Hashes still owed by the block wait in due_hashes, oldest first.
  logic [31:0] shadow_seed;
  logic [31:0] shadow_hash;
  logic [31:0] due_hashes[$];

  // Zero gaps on both sides while set, so back-to-back stretches occur.
  bit steady_flow;

  int beats_sent;
  int keys_sent;
  int hashes_checked;
  int seed_writes;
  int mismatches;
  int idle_cycles;

  // Directed table, run with the reset seed:
  //   a last word straight after reset finalizes a zero hash -> 0;
  //   an empty key whose length equals the seed also finalizes zero -> 0;
  //   empty key of length zero; full words of all ones and all zeros;
  //   one, two and three byte tails with the unused bytes set;
  //   a maximum stated length with a zero-byte word in the middle;
  //   byte counts above four taken as full words;
  //   a tail on a word that is not last;
  //   words with no first mark carrying on from a finished hash;
  //   a key restarted by a second first word before its last.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{32'h0000_0000, 3'd0, 1'b0, 1'b1, 31'd0},          1'b1, 32'h0000_0000},
    '{'{32'hFFFF_FFFF, 3'd0, 1'b1, 1'b1, 31'd5381},       1'b1, 32'h0000_0000},
    '{'{32'h1234_5678, 3'd0, 1'b1, 1'b1, 31'd0},          1'b0, 32'h0},
    '{'{32'hFFFF_FFFF, 3'd4, 1'b1, 1'b1, 31'd4},          1'b0, 32'h0},
    '{'{32'h0000_0000, 3'd4, 1'b1, 1'b1, 31'd4},          1'b0, 32'h0},
    '{'{32'hFFFF_FFFF, 3'd1, 1'b1, 1'b1, 31'd1},          1'b0, 32'h0},
    '{'{32'hFFFF_FFFF, 3'd2, 1'b1, 1'b1, 31'd2},          1'b0, 32'h0},
    '{'{32'hFFFF_FFFF, 3'd3, 1'b1, 1'b1, 31'd3},          1'b0, 32'h0},
    '{'{32'h0403_0201, 3'd4, 1'b1, 1'b0, 31'h7FFF_FFFF},  1'b0, 32'h0},
    '{'{32'hDEAD_BEEF, 3'd0, 1'b0, 1'b0, 31'd0},          1'b0, 32'h0},
    '{'{32'hFF0A_0B0C, 3'd3, 1'b0, 1'b1, 31'h7FFF_FFFF},  1'b0, 32'h0},
    '{'{32'hA5A5_A5A5, 3'd7, 1'b1, 1'b0, 31'd8},          1'b0, 32'h0},
    '{'{32'h5A5A_5A5A, 3'd5, 1'b0, 1'b1, 31'd8},          1'b0, 32'h0},
    '{'{32'hFFFF_00FF, 3'd2, 1'b1, 1'b0, 31'd6},          1'b0, 32'h0},
    '{'{32'h8000_0001, 3'd4, 1'b0, 1'b1, 31'd0},          1'b0, 32'h0},
    '{'{32'h1111_1111, 3'd4, 1'b0, 1'b0, 31'd0},          1'b0, 32'h0},
    '{'{32'h0000_00FE, 3'd1, 1'b0, 1'b1, 31'd0},          1'b0, 32'h0},
    '{'{32'h7FFF_FFFE, 3'd6, 1'b1, 1'b1, 31'd4},          1'b0, 32'h0},
    '{'{32'hCAFE_F00D, 3'd4, 1'b1, 1'b0, 31'd12},         1'b0, 32'h0},
    '{'{32'h0BAD_CAFE, 3'd4, 1'b1, 1'b1, 31'd4},          1'b0, 32'h0}
  };

  // Fold one accepted key word into the shadow hash. Returns 1 when the word
  // closes a key; digest then holds the finished hash.
  function automatic bit fold_word(input key_beat_t b, output logic [31:0] digest);
    logic [31:0] h;
    logic [31:0] k;
    logic [31:0] mask;
    // A first word restarts from the seed mixed with the stated length.
    h = b.first ? (shadow_seed ^ {1'b0, b.klen}) : shadow_hash;
    if (b.count >= 3'd4) begin
      // Full block; counts above four land here too.
      k = b.word * HASH_MUL;
      k = k ^ (k >> 24);
      k = k * HASH_MUL;
      h = (h * HASH_MUL) ^ k;
    end else if (b.count != 3'd0) begin
      // Tail: only the valid low bytes go in.
      mask = (b.count == 3'd1) ? 32'h0000_00FF :
             (b.count == 3'd2) ? 32'h0000_FFFF : 32'h00FF_FFFF;
      h = (h ^ (b.word & mask)) * HASH_MUL;
    end
    if (b.last) begin
      h = h ^ (h >> 13);
      h = h * HASH_MUL;
      h = h ^ (h >> 15);
    end
    shadow_hash = h;
    digest = h;
    return b.last;
  endfunction

  // Present one key word beat after a random gap, hold it until the block
  // takes it, then predict. Valid stays high across back-to-back beats.
  task automatic send_beat(input key_beat_t b, input logic known,
                           input logic [31:0] known_hash);
    int gap;
    logic [31:0] digest;
    gap = steady_flow ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      key_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    key_ch.valid      <= 1'b1;
    key_ch.data_word  <= b.word;
    key_ch.byte_count <= b.count;
    key_ch.first_word <= b.first;
    key_ch.last_word  <= b.last;
    key_ch.key_length <= b.klen;
    // Sample the handshake at the falling edge, where everything has settled;
    // the beat moves at the rising edge that follows.
    do @(negedge clk); while (!key_ch.ready);
    @(posedge clk);
    beats_sent++;
    if (fold_word(b, digest))
      due_hashes.push_back(known ? known_hash : digest);
  endtask

  // Send a key of nbytes random bytes: full words, then a tail.
  // Now and then the stated length disagrees with the bytes, and a broken key
  // drops its last mark so the next first word has to restart the hash.
  task automatic send_key(input int nbytes, input bit broken);
    int left;
    logic [KLEN_W-1:0] stated;
    key_beat_t b;
    stated = ($urandom_range(0, 9) == 0) ? KLEN_W'($urandom) : KLEN_W'(nbytes);
    left = nbytes;
    keys_sent++;
    do begin
      b.word  = $urandom;
      b.count = (left >= 4) ? 3'd4 : COUNT_W'(left);
      b.first = (left == nbytes);
      b.last  = (left <= 4) && !broken;
      // The length only matters on the first word; toggle it elsewhere.
      b.klen  = b.first ? stated : KLEN_W'($urandom);
      send_beat(b, 1'b0, 32'h0);
      left -= b.count;
    end while (left > 0);
  endtask

  // One seed phase of random traffic: mostly whole keys of random size and
  // content, the rest stray words with any count and marks. Close on a clean
  // key so the block ends the phase with nothing half done.
  task automatic run_keys(input int budget);
    int start;
    int roll;
    int nbytes;
    key_beat_t b;
    start = beats_sent;
    while (beats_sent - start < budget) begin
      if ($urandom_range(0, 15) == 0)
        steady_flow = !steady_flow;
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        b.word  = $urandom;
        b.count = COUNT_W'($urandom_range(0, 7));
        b.first = 1'($urandom_range(0, 1));
        b.last  = ($urandom_range(0, 2) == 0);
        b.klen  = KLEN_W'($urandom);
        send_beat(b, 1'b0, 32'h0);
      end else begin
        nbytes = (roll < 17) ? 0 :
                 (roll < 80) ? $urandom_range(1, 24) :
                 (roll < 96) ? $urandom_range(25, 80) : $urandom_range(81, 160);
        send_key(nbytes, $urandom_range(0, 29) == 0);
      end
    end
    steady_flow = 1'b0;
    send_key($urandom_range(1, 12), 1'b0);
  endtask

  // Drop valid, wait for every owed hash, then let the pipeline empty.
  task automatic drain_block();
    key_ch.valid <= 1'b0;
    while (due_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the seed while the block is idle; it applies from the next first word.
  task automatic write_seed(input logic [31:0] seed);
    drain_block();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= seed;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_seed = seed;
    seed_writes++;
  endtask

  initial begin : stimulus
    logic [31:0] seed_plan [SEED_PHASES];
    rst                = 1'b1;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    key_ch.valid       = 1'b0;
    key_ch.data_word   = '0;
    key_ch.byte_count  = '0;
    key_ch.first_word  = 1'b0;
    key_ch.last_word   = 1'b0;
    key_ch.key_length  = '0;
    shadow_seed        = RESET_SEED;
    shadow_hash        = 32'h0;
    steady_flow        = 1'b0;
    // Extremes first, the reset value last so it is also written explicitly.
    seed_plan = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, 32'h8000_0001, $urandom,
                  RESET_SEED};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_beat(directed_rows[i].beat, directed_rows[i].known, directed_rows[i].known_hash);

    // Each seed change waits for the block to empty, so the sender pauses
    // until every owed hash has arrived at least once per phase.
    foreach (seed_plan[p]) begin
      write_seed(seed_plan[p]);
      run_keys(PHASE_BEATS);
    end

    drain_block();
    if (due_hashes.size() != 0) begin
      $display("%0t: %0d hashes never arrived", $time, due_hashes.size());
      mismatches++;
    end

    $display("Ran %0d key word beats (%0d random keys plus stray words) over %0d seeds,",
             beats_sent, keys_sent, seed_writes + 1);
    $display("with random gaps and stalls on both channels; %0d hash beats checked.",
             hashes_checked);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Hash sink: stall at random, take each hash beat and compare it with the
  // oldest one owed. Ready stays high across back-to-back beats.
  initial begin : hash_sink
    int stall;
    logic [WORD_W-1:0] got;
    logic [31:0] want;
    hash_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        hash_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      hash_ch.ready <= 1'b1;
      do @(negedge clk); while (!hash_ch.valid);
      got = hash_ch.hash_value;
      @(posedge clk);
      if (due_hashes.size() == 0) begin
        $display("%0t: unexpected hash beat, expected none, actual %08h", $time, got);
        mismatches++;
      end else begin
        want = due_hashes.pop_front();
        hashes_checked++;
        if (got !== want) begin
          $display("%0t: hash_value mismatch, expected %08h, actual %08h",
                   $time, want, got);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: count cycles with no beat on either channel.
  always @(negedge clk) begin
    if (rst || (key_ch.valid && key_ch.ready) || (hash_ch.valid && hash_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles, %0d hashes owed",
                 $time, IDLE_LIMIT, due_hashes.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule
